FILE: rtl/core/sttq_pkg.sv
// shared constants, codes and types of the sorted timer queue
package sttq_pkg;

  // pool size and derived widths
  localparam int NUM_SLOTS = 32;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int LINK_W    = $clog2(NUM_SLOTS + 1);
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(NUM_SLOTS);

  // fixed field widths
  localparam int OP_W   = 3;
  localparam int SLOT_FW = 5;
  localparam int DEST_W = 3;
  localparam int DATA_W = 32;
  localparam int TICK_W = 32;

  // request queue between front and engine
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // result kinds
  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_ALLOC    = 3'd1,
    OP_FREE     = 3'd2,
    OP_SET_DATA = 3'd3,
    OP_ARM      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_RUN   = 2'd2
  } slot_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_TICK,
    S_UNLINK,
    S_ARM_SET,
    S_INS_WALK,
    S_INS_PREV
  } eng_state_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] delay;
    logic [DATA_W-1:0] data;
    logic [DEST_W-1:0] dest;
  } cmd_t;

endpackage

FILE: rtl/core/sorted_timer_queue.sv
// top level of the sorted timer queue
//
//  channel   handshake              fields
//  request   req_valid/req_ready    operation, slot, delay_ticks, payload, destination
//  response  rsp_valid/rsp_ready    kind, ok, slot_out, dest_out, data_out, last
//
// a request enters a two-entry queue; the engine then checks one slot status
// per cycle on alloc, pops expired slots from the list head on tick, and on
// free and arm walks the list, reading one link per cycle.
// synchronous reset puts every slot free, empties the list, zeroes the count.
// a stalled response holds the engine; the queue keeps taking requests meanwhile until it is full.
module sorted_timer_queue import sttq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic [OP_W-1:0]          operation,
  input  logic [SLOT_FW-1:0]       slot,
  input  logic [TICK_W-1:0]        delay_ticks,
  input  logic signed [DATA_W-1:0] payload,
  input  logic [DEST_W-1:0]        destination,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic                     kind,
  output logic                     ok,
  output logic [SLOT_FW-1:0]       slot_out,
  output logic [DEST_W-1:0]        dest_out,
  output logic signed [DATA_W-1:0] data_out,
  output logic                     last
);

  logic              cmd_valid;
  logic              cmd_ready;
  cmd_t              cmd;
  logic [DATA_W-1:0] data_raw;

  // request decode and queue
  sttq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .operation   (operation),
    .slot        (slot),
    .delay_ticks (delay_ticks),
    .payload     (payload),
    .destination (destination),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  // timer engine
  sttq_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .kind      (kind),
    .ok        (ok),
    .slot_out  (slot_out),
    .dest_out  (dest_out),
    .data_out  (data_raw),
    .last      (last)
  );

  assign data_out = data_raw;

endmodule

FILE: rtl/core/sttq_front.sv
// request decode and short command queue in front of the timer engine
module sttq_front import sttq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic [OP_W-1:0]          operation,
  input  logic [SLOT_FW-1:0]       slot,
  input  logic [TICK_W-1:0]        delay_ticks,
  input  logic signed [DATA_W-1:0] payload,
  input  logic [DEST_W-1:0]        destination,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output cmd_t                     cmd
);

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              keep;
  logic              push;
  logic              pop;
  cmd_t              incoming;

  // drop unknown operations and slots beyond the pool
  always_comb begin
    keep = 1'b0;
    if (operation inside {OP_TICK, OP_ALLOC}) begin
      keep = 1'b1;
    end else if (operation inside {OP_FREE, OP_SET_DATA, OP_ARM}) begin
      keep = (32'(slot) < NUM_SLOTS);
    end
  end

  always_comb begin
    incoming.op    = op_t'(operation);
    incoming.slot  = SLOT_W'(slot);
    incoming.delay = delay_ticks;
    incoming.data  = payload;
    incoming.dest  = destination;
  end

  assign req_ready = (fill != QCNT_W'(QDEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = q[rd_ptr];
  assign push      = req_valid && req_ready && keep;
  assign pop       = cmd_valid && cmd_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/sttq_engine.sv
// timer engine: slot pool, deadline ordered list walker and result register
module sttq_engine import sttq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic               kind,
  output logic               ok,
  output logic [SLOT_FW-1:0] slot_out,
  output logic [DEST_W-1:0]  dest_out,
  output logic [DATA_W-1:0]  data_out,
  output logic               last
);

  // slot storage
  slot_state_t       status   [NUM_SLOTS];
  logic [TICK_W-1:0] deadline [NUM_SLOTS];
  logic [DATA_W-1:0] pay_mem  [NUM_SLOTS];
  logic [DEST_W-1:0] dest_mem [NUM_SLOTS];
  logic [LINK_W-1:0] link_mem [NUM_SLOTS];

  eng_state_t        state;
  eng_state_t        state_next;
  logic [LINK_W-1:0] head;
  logic [TICK_W-1:0] tick_count;
  logic [LINK_W-1:0] cur;
  logic [LINK_W-1:0] prev;
  logic [SLOT_W-1:0] tgt;
  op_t               op;
  logic [TICK_W-1:0] arm_delay;
  logic [TICK_W-1:0] dl;
  logic [SLOT_W-1:0] idx;
  logic              have_pend;
  logic [SLOT_W-1:0] pend_slot;
  logic [DEST_W-1:0] pend_dest;
  logic [DATA_W-1:0] pend_data;

  logic [LINK_W-1:0] rd_sel;
  logic [SLOT_W-1:0] rd_idx;
  logic [TICK_W-1:0] rd_dl;
  logic [LINK_W-1:0] rd_link;
  logic              fire;
  logic              out_free;
  logic              idx_last;
  logic              hit;
  logic              walk_stop;
  logic [LINK_W-1:0] tgt_link;

  logic              link_we;
  logic [LINK_W-1:0] link_wa;
  logic [LINK_W-1:0] link_wd;
  logic              emit;
  logic              emit_kind;
  logic              emit_ok;
  logic [SLOT_W-1:0] emit_slot;
  logic [DEST_W-1:0] emit_dest;
  logic [DATA_W-1:0] emit_data;
  logic              emit_last;
  logic              take;

  // single read port into the list: head while ticking, walk pointer otherwise
  assign rd_sel    = (state == S_TICK) ? head : cur;
  assign rd_idx    = rd_sel[SLOT_W-1:0];
  assign rd_dl     = deadline[rd_idx];
  assign rd_link   = link_mem[rd_idx];
  assign fire      = (head != END_MARK) && (rd_dl <= tick_count);
  assign out_free  = !rsp_valid || rsp_ready;
  assign idx_last  = (idx == SLOT_W'(NUM_SLOTS - 1));
  assign tgt_link  = LINK_W'(tgt);
  assign hit       = (cur != END_MARK) && (cur == tgt_link);
  assign walk_stop = (cur == END_MARK) || !(dl > rd_dl);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_TICK:  state_next = S_TICK;
            OP_ALLOC: state_next = S_ALLOC;
            OP_FREE:  state_next = (status[cmd.slot] == ST_RUN) ? S_UNLINK : S_IDLE;
            OP_ARM:   state_next = (status[cmd.slot] == ST_RUN) ? S_UNLINK : S_ARM_SET;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_ALLOC: begin
        if (out_free && (status[idx] == ST_FREE || idx_last)) begin
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        if (!fire && (!have_pend || out_free)) begin
          state_next = S_IDLE;
        end
      end
      S_UNLINK: begin
        if (cur == END_MARK || hit) begin
          state_next = (op == OP_ARM) ? S_ARM_SET : S_IDLE;
        end
      end
      S_ARM_SET:  state_next = S_INS_WALK;
      S_INS_WALK: begin
        if (walk_stop) begin
          state_next = S_INS_PREV;
        end
      end
      S_INS_PREV: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // strobes: link writes, result emission, tick pops
  always_comb begin
    cmd_ready = (state == S_IDLE);
    link_we   = 1'b0;
    link_wa   = prev;
    link_wd   = rd_link;
    emit      = 1'b0;
    emit_kind = KIND_ALLOC;
    emit_ok   = 1'b0;
    emit_slot = '0;
    emit_dest = '0;
    emit_data = '0;
    emit_last = 1'b1;
    take      = 1'b0;
    case (state)
      S_ALLOC: begin
        if (out_free && status[idx] == ST_FREE) begin
          emit      = 1'b1;
          emit_ok   = 1'b1;
          emit_slot = idx;
        end else if (out_free && idx_last) begin
          emit = 1'b1;
        end
      end
      S_TICK: begin
        take = fire && (!have_pend || out_free);
        if (have_pend && out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_EXPIRY;
          emit_ok   = 1'b1;
          emit_slot = pend_slot;
          emit_dest = pend_dest;
          emit_data = pend_data;
          emit_last = !fire;
        end
      end
      S_UNLINK: begin
        if (hit && prev != END_MARK) begin
          link_we = 1'b1;
          link_wa = prev;
          link_wd = rd_link;
        end
      end
      S_INS_WALK: begin
        if (walk_stop) begin
          link_we = 1'b1;
          link_wa = tgt_link;
          link_wd = cur;
        end
      end
      S_INS_PREV: begin
        if (prev != END_MARK) begin
          link_we = 1'b1;
          link_wa = prev;
          link_wd = tgt_link;
        end
      end
      default: ;
    endcase
  end

  // slot payload, deadline and link storage
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa[SLOT_W-1:0]] <= link_wd;
    end
    if (state == S_ARM_SET) begin
      deadline[tgt] <= arm_delay + tick_count;
    end
    if (state == S_IDLE && cmd_valid && cmd.op == OP_SET_DATA) begin
      pay_mem[cmd.slot]  <= cmd.data;
      dest_mem[cmd.slot] <= cmd.dest;
    end
  end

  // working registers without reset
  always_ff @(posedge clk) begin
    if (emit) begin
      kind     <= emit_kind;
      ok       <= emit_ok;
      slot_out <= SLOT_FW'(emit_slot);
      dest_out <= emit_dest;
      data_out <= emit_data;
      last     <= emit_last;
    end
    case (state)
      S_IDLE: begin
        op        <= cmd.op;
        tgt       <= cmd.slot;
        arm_delay <= cmd.delay;
        cur       <= head;
        prev      <= END_MARK;
        idx       <= '0;
      end
      S_ALLOC: begin
        if (status[idx] != ST_FREE && !idx_last) begin
          idx <= idx + 1'b1;
        end
      end
      S_TICK: begin
        if (take) begin
          pend_slot <= rd_idx;
          pend_dest <= dest_mem[rd_idx];
          pend_data <= pay_mem[rd_idx];
        end
      end
      S_UNLINK: begin
        if (!hit && cur != END_MARK) begin
          prev <= cur;
          cur  <= rd_link;
        end
      end
      S_ARM_SET: begin
        dl   <= arm_delay + tick_count;
        cur  <= head;
        prev <= END_MARK;
      end
      S_INS_WALK: begin
        if (!walk_stop) begin
          prev <= cur;
          cur  <= rd_link;
        end
      end
      default: ;
    endcase
  end

  // control state, slot status and list head
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= END_MARK;
      tick_count <= '0;
      rsp_valid  <= 1'b0;
      have_pend  <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        status[i] <= ST_FREE;
      end
    end else begin
      state <= state_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          have_pend <= 1'b0;
          if (cmd_valid) begin
            if (cmd.op == OP_TICK) begin
              tick_count <= tick_count + 1'b1;
            end
            if (cmd.op == OP_FREE && status[cmd.slot] != ST_RUN) begin
              status[cmd.slot] <= ST_FREE;
            end
          end
        end
        S_ALLOC: begin
          if (emit && emit_ok) begin
            status[idx] <= ST_ALLOC;
          end
        end
        S_TICK: begin
          if (take) begin
            status[rd_idx] <= ST_ALLOC;
            head           <= rd_link;
            have_pend      <= 1'b1;
          end else if (emit) begin
            have_pend <= 1'b0;
          end
        end
        S_UNLINK: begin
          if (hit && prev == END_MARK) begin
            head <= rd_link;
          end
          if ((hit || cur == END_MARK) && op == OP_FREE) begin
            status[tgt] <= ST_FREE;
          end
        end
        S_ARM_SET: begin
          status[tgt] <= ST_RUN;
        end
        S_INS_PREV: begin
          if (prev == END_MARK) begin
            head <= tgt_link;
          end
        end
        default: ;
      endcase
    end
  end

  // the list head is always a running slot
  a_head_running: assert property (@(posedge clk) disable iff (rst)
    head != END_MARK |-> status[head[SLOT_W-1:0]] == ST_RUN)
    else $error("list head is not a running slot");

  // no held expiry outside a tick walk
  a_pend_only_in_tick: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !have_pend)
    else $error("pending expiry left over after tick");

  // expiry results always report success
  a_expiry_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind == KIND_EXPIRY |-> ok)
    else $error("expiry result without ok");

  // tick count only ever steps by one
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && tick_count != $past(tick_count)
      |-> tick_count == TICK_W'($past(tick_count) + 1'b1))
    else $error("tick count jumped");

  // a command is taken only when the engine is idle
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |-> state == S_IDLE)
    else $error("command taken while busy");

endmodule

FILE: tb/sorted_timer_queue_check.sv
// checker for the sorted timer queue: timer list predictor and response comparison
module sorted_timer_queue_check import sttq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  input  logic                     req_ready,
  input  logic [OP_W-1:0]          operation,
  input  logic [SLOT_FW-1:0]       slot,
  input  logic [TICK_W-1:0]        delay_ticks,
  input  logic signed [DATA_W-1:0] payload,
  input  logic [DEST_W-1:0]        destination,
  input  logic                     rsp_valid,
  input  logic                     rsp_ready,
  input  logic                     kind,
  input  logic                     ok,
  input  logic [SLOT_FW-1:0]       slot_out,
  input  logic [DEST_W-1:0]        dest_out,
  input  logic signed [DATA_W-1:0] data_out,
  input  logic                     last,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic              kind;
    logic              ok;
    logic [SLOT_FW-1:0] slot;
    logic [DEST_W-1:0]  dest;
    logic [DATA_W-1:0]  data;
    logic              last;
  } reply_t;

  // shadow timer pool
  slot_state_t       pool_state [NUM_SLOTS];
  logic [TICK_W-1:0] pool_due   [NUM_SLOTS];
  logic [DATA_W-1:0] pool_data  [NUM_SLOTS];
  logic [DEST_W-1:0] pool_dest  [NUM_SLOTS];
  int                due_order  [$];
  logic [TICK_W-1:0] ticks_now;
  reply_t            replies_due [$];

  assign pending = replies_due.size();

  // drop a slot from the ordered running list
  function automatic void drop_slot(int s);
    foreach (due_order[i]) if (due_order[i] == s) begin
      due_order.delete(i);
      return;
    end
  endfunction

  // apply one request to the shadow pool and queue its replies
  function automatic void apply_request(op_t op, int s, logic [TICK_W-1:0] dly,
                                        logic [DATA_W-1:0] pay, logic [DEST_W-1:0] dst);
    int     pos;
    int     h;
    int     first;
    reply_t r;
    first = replies_due.size();
    case (op)
      OP_TICK: begin
        ticks_now = ticks_now + 1'b1;
        while (due_order.size() > 0 && pool_due[due_order[0]] <= ticks_now) begin
          h = due_order.pop_front();
          pool_state[h] = ST_ALLOC;
          r = '{KIND_EXPIRY, 1'b1, SLOT_FW'(h), pool_dest[h], pool_data[h], 1'b0};
          replies_due.push_back(r);
        end
      end
      OP_ALLOC: begin
        r = '{KIND_ALLOC, 1'b0, '0, '0, '0, 1'b0};
        for (int i = 0; i < NUM_SLOTS; i++) if (pool_state[i] == ST_FREE) begin
          pool_state[i] = ST_ALLOC;
          r.ok = 1'b1;
          r.slot = SLOT_FW'(i);
          break;
        end
        replies_due.push_back(r);
      end
      OP_FREE: begin
        if (pool_state[s] == ST_RUN) drop_slot(s);
        pool_state[s] = ST_FREE;
      end
      OP_SET_DATA: begin
        pool_data[s] = pay;
        pool_dest[s] = dst;
      end
      OP_ARM: begin
        if (pool_state[s] == ST_RUN) drop_slot(s);
        pool_due[s] = dly + ticks_now;
        pool_state[s] = ST_RUN;
        pos = due_order.size();
        foreach (due_order[i]) if (pool_due[s] <= pool_due[due_order[i]]) begin
          pos = i;
          break;
        end
        due_order.insert(pos, s);
      end
      default: ;
    endcase
    if (replies_due.size() > first) replies_due[replies_due.size()-1].last = 1'b1;
  endfunction

  // watch both channels
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst) begin
      fail_count <= 0;
      ticks_now = '0;
      due_order.delete();
      replies_due.delete();
      foreach (pool_state[i]) begin
        pool_state[i] = ST_FREE;
        pool_due[i] = '0;
        pool_data[i] = '0;
        pool_dest[i] = '0;
      end
    end else begin
      if (req_valid && req_ready)
        apply_request(op_t'(operation), int'(slot), delay_ticks, payload, destination);
      if (rsp_valid && rsp_ready) begin
        got = '{kind, ok, slot_out, dest_out, data_out, last};
        if (replies_due.size() == 0) begin
          $display("%0t unexpected response %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = replies_due.pop_front();
          if (got !== want) begin
            $display("%0t response mismatch: expected %p actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sorted_timer_queue_test.sv
// stimulus and verdict for the sorted timer queue
module sorted_timer_queue_test;
  import sttq_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_ready;
  logic [OP_W-1:0]          operation = '0;
  logic [SLOT_FW-1:0]       slot = '0;
  logic [TICK_W-1:0]        delay_ticks = '0;
  logic signed [DATA_W-1:0] payload = '0;
  logic [DEST_W-1:0]        destination = '0;
  logic                     rsp_valid;
  logic                     rsp_ready = 1'b0;
  logic                     kind;
  logic                     ok;
  logic [SLOT_FW-1:0]       slot_out;
  logic [DEST_W-1:0]        dest_out;
  logic signed [DATA_W-1:0] data_out;
  logic                     last;
  int                       fail_count;
  int                       pending;
  int                       cycle_count = 0;
  bit                       calm = 1'b0;
  bit                       data_set [NUM_SLOTS];

  localparam int CYCLE_LIMIT = 400000;

  always #1 clk = ~clk;

  sorted_timer_queue dut (.*);
  sorted_timer_queue_check chk (.*);

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_timer_queue regression: fail");
      $finish;
    end
  end

  // response side stalls
  always @(posedge clk)
    rsp_ready <= calm || ($urandom_range(99) >= 25);

  // send one request, with a random gap first; valid stays up for back to back requests
  task automatic send(op_t op, int s, logic [TICK_W-1:0] dly,
                      logic [DATA_W-1:0] pay, logic [DEST_W-1:0] dst);
    while (!calm && $urandom_range(99) < 25) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    operation   <= op;
    slot        <= SLOT_FW'(s);
    delay_ticks <= dly;
    payload     <= pay;
    destination <= dst;
    if (op == OP_SET_DATA) data_set[s] = 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  // random request, arming only slots that have data
  task automatic random_request();
    int s;
    int pick;
    logic [TICK_W-1:0] dly;
    s = $urandom_range(NUM_SLOTS - 1);
    pick = $urandom_range(99);
    dly = ($urandom_range(9) == 0) ? $urandom : $urandom_range(6);
    if (pick < 35) send(OP_TICK, s, $urandom, $urandom, DEST_W'($urandom));
    else if (pick < 45) send(OP_ALLOC, s, $urandom, $urandom, DEST_W'($urandom));
    else if (pick < 55) send(OP_FREE, s, $urandom, $urandom, DEST_W'($urandom));
    else if (pick < 68) send(OP_SET_DATA, s, $urandom, $urandom, DEST_W'($urandom));
    else if (pick < 97) begin
      if (!data_set[s]) send(OP_SET_DATA, s, $urandom, $urandom, DEST_W'($urandom));
      send(OP_ARM, s, dly, $urandom, DEST_W'($urandom));
    end else send(op_t'($urandom_range(7, 5)), s, $urandom, $urandom, DEST_W'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: alloc until exhausted, extremes, equal deadlines
    for (int i = 0; i < 3; i++) send(OP_ALLOC, 0, '0, '0, '0);
    send(OP_SET_DATA, 0, '0, 32'h7fffffff, 3'd7);
    send(OP_SET_DATA, 31, '0, 32'h80000000, 3'd0);
    send(OP_SET_DATA, 1, '0, 32'hffffffff, 3'd5);
    send(OP_ARM, 0, 32'd2, '0, '0);
    send(OP_ARM, 31, 32'd2, '0, '0);
    send(OP_ARM, 1, 32'hffffffff, '0, '0);
    send(OP_ARM, 1, 32'd0, '0, '0);
    send(OP_TICK, 0, '0, '0, '0);
    send(OP_TICK, 0, '0, '0, '0);
    send(OP_ARM, 0, 32'd5, '0, '0);
    send(OP_FREE, 0, '0, '0, '0);
    send(OP_ARM, 2, 32'd1, '0, '0);
    send(OP_SET_DATA, 2, '0, 32'h12345678, 3'd2);
    send(op_t'(3'd7), 0, '0, '0, '0);
    for (int i = 0; i < 31; i++) send(OP_ALLOC, 0, '0, '0, '0);
    send(OP_TICK, 0, '0, '0, '0);

    // random, with a calm stretch in the middle
    for (int n = 0; n < 400; n++) begin
      calm = (n >= 150 && n < 220);
      random_request();
    end
    calm = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) send(OP_TICK, 0, '0, '0, '0);
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("sorted_timer_queue regression: pass");
    else
      $display("sorted_timer_queue regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sttq_pkg.sv
rtl/core/sttq_front.sv
rtl/core/sttq_engine.sv
rtl/core/sorted_timer_queue.sv
tb/sorted_timer_queue_check.sv
tb/sorted_timer_queue_test.sv
